@@ rtl/rcsb_pkg.sv @@
// ----------------------------------------------------------------------------
// rcsb_pkg: shared types and constants of the RC frame decoder
// Frame store geometry, protocol constants, register map and the entry
// that travels from the byte front end to the decode back end.
// ----------------------------------------------------------------------------
package rcsb_pkg;

  localparam int BUFFER_BYTES = 32;
  localparam int POS_W        = $clog2(BUFFER_BYTES + 1);
  localparam int IDX_W        = $clog2(BUFFER_BYTES);

  localparam int NUM_CH       = 10;
  localparam int CH_W         = 16;

  localparam int STICK_BASE   = 0;
  localparam int NUM_STICKS   = 4;
  localparam int SWITCH_BASE  = 4;
  localparam int NUM_SWITCHES = 4;
  localparam int KNOB_BASE    = 8;
  localparam int NUM_KNOBS    = 2;

  localparam logic [7:0] SBUS_SYNC = 8'h0F;
  localparam logic [7:0] IBUS_SYNC = 8'h20;
  localparam int SBUS_CH_W           = 11;
  localparam logic [CH_W-1:0] SBUS_OFFSET = 16'd1024;
  localparam logic [CH_W-1:0] IBUS_CENTER = 16'd1500;
  localparam logic [15:0] CKSUM_INIT = 16'hFFFF;
  localparam int CKSUM_BYTES  = 30;
  localparam int CKSUM_LO_IDX = 30;
  localparam int CKSUM_HI_IDX = 31;

  localparam int DEADBAND     = 10;

  // Quotient by the switch divisor through a rounded-up reciprocal; exact
  // for every magnitude a 16-bit signed channel can take.
  localparam int SWITCH_DIV         = 500;
  localparam int SWITCH_RECIP_SHIFT = 24;
  localparam logic [15:0] SWITCH_RECIP =
    16'(((1 << SWITCH_RECIP_SHIFT) + SWITCH_DIV - 1) / SWITCH_DIV);
  localparam int SWITCH_Q_W         = 7;
  localparam int MAG_W              = CH_W + 1;
  localparam int PROD_W             = MAG_W + 16;

  localparam logic MODE_SBUS = 1'b0;
  localparam logic MODE_IBUS = 1'b1;

  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_PROTOCOL_MODE = '0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [BUFFER_BYTES-1:0][7:0] frame_bytes_t;

  typedef struct packed {
    logic                       ok;
    logic [NUM_CH-1:0][CH_W-1:0] ch;
  } rcsb_frame_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } rcsb_queue_status_t;

endpackage

@@ rtl/rcsb_if.sv @@
// ----------------------------------------------------------------------------
// rcsb_if: byte and result channels of the RC frame decoder
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rcsb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

interface rcsb_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] stick_right_x;
  logic signed [15:0] stick_right_y;
  logic signed [15:0] stick_left_y;
  logic signed [15:0] stick_left_x;
  logic signed [7:0]  switch_a;
  logic signed [7:0]  switch_b;
  logic signed [7:0]  switch_c;
  logic signed [7:0]  switch_d;
  logic signed [15:0] knob_a;
  logic signed [15:0] knob_b;
  logic               frame_ok;

  modport source (output valid, stick_right_x, stick_right_y, stick_left_y,
                  stick_left_x, switch_a, switch_b, switch_c, switch_d,
                  knob_a, knob_b, frame_ok, input ready);
  modport sink   (input valid, stick_right_x, stick_right_y, stick_left_y,
                  stick_left_x, switch_a, switch_b, switch_c, switch_d,
                  knob_a, knob_b, frame_ok, output ready);
endinterface

@@ rtl/rcsb_front.sv @@
// ----------------------------------------------------------------------------
// rcsb_front: byte capture and frame classification
// Writes bytes into the frame store, keeps a running byte sum for the IBUS
// checksum and, on a frame-end beat, checks the header and unpacks channels.
// ----------------------------------------------------------------------------
module rcsb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 protocol_mode,
  rcsb_byte_if.sink            rx,
  output logic                 push_valid,
  input  logic                 push_ready,
  output rcsb_pkg::rcsb_frame_t push_entry
);

  logic [rcsb_pkg::POS_W-1:0] pos;
  rcsb_pkg::frame_bytes_t     store;
  rcsb_pkg::frame_bytes_t     eff;
  logic [15:0]                sum;
  logic [15:0]                sum_next;
  logic                       accept;
  logic                       wr;
  logic [rcsb_pkg::IDX_W-1:0] widx;
  logic [rcsb_pkg::NUM_CH-1:0][rcsb_pkg::CH_W-1:0] sbus_ch;
  logic [rcsb_pkg::NUM_CH-1:0][rcsb_pkg::CH_W-1:0] ibus_ch;
  logic                       sbus_ok;
  logic                       ibus_ok;

  // Bytes past the end of the store read as zero.
  function automatic logic [7:0] fetch(input rcsb_pkg::frame_bytes_t a, input int idx);
    logic [rcsb_pkg::IDX_W-1:0] i;
    i = idx[rcsb_pkg::IDX_W-1:0];
    if (idx >= rcsb_pkg::BUFFER_BYTES) begin
      return 8'h00;
    end
    return a[i];
  endfunction

  assign rx.ready   = push_ready;
  assign accept     = rx.valid && rx.ready;
  assign wr         = accept && (pos < rcsb_pkg::POS_W'(rcsb_pkg::BUFFER_BYTES));
  assign widx       = pos[rcsb_pkg::IDX_W-1:0];
  assign push_valid = accept && rx.frame_end;

  // The sum covers the checksummed positions of the store as they stand,
  // so it stays right when a short buffer leaves older bytes behind.
  always_comb begin
    sum_next = sum;
    if (wr && (pos < rcsb_pkg::POS_W'(rcsb_pkg::CKSUM_BYTES))) begin
      sum_next = sum - {8'h00, store[widx]} + {8'h00, rx.rx_byte};
    end
  end

  always_comb begin
    eff = store;
    if (wr) begin
      eff[widx] = rx.rx_byte;
    end
  end

  always_comb begin
    int          bitpos;
    int          b;
    logic [23:0] w;
    logic [rcsb_pkg::SBUS_CH_W-1:0] raw;
    for (int k = 0; k < rcsb_pkg::NUM_CH; k++) begin
      bitpos = rcsb_pkg::SBUS_CH_W * k;
      b      = 1 + (bitpos >> 3);
      w      = {fetch(eff, b + 2), fetch(eff, b + 1), fetch(eff, b)};
      raw    = rcsb_pkg::SBUS_CH_W'(w >> bitpos[2:0]);
      sbus_ch[k] = {{(rcsb_pkg::CH_W - rcsb_pkg::SBUS_CH_W){1'b0}}, raw}
                   - rcsb_pkg::SBUS_OFFSET;
      ibus_ch[k] = {fetch(eff, 3 + 2 * k), fetch(eff, 2 + 2 * k)} - rcsb_pkg::IBUS_CENTER;
    end
  end

  assign sbus_ok = (fetch(eff, 0) == rcsb_pkg::SBUS_SYNC);
  assign ibus_ok = (fetch(eff, 0) == rcsb_pkg::IBUS_SYNC) &&
                   ((rcsb_pkg::CKSUM_INIT - sum_next) ==
                    {fetch(eff, rcsb_pkg::CKSUM_HI_IDX), fetch(eff, rcsb_pkg::CKSUM_LO_IDX)});

  always_comb begin
    if (protocol_mode == rcsb_pkg::MODE_IBUS) begin
      push_entry.ok = ibus_ok;
      push_entry.ch = ibus_ch;
    end else begin
      push_entry.ok = sbus_ok;
      push_entry.ch = sbus_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      store <= '0;
      sum   <= '0;
    end else begin
      if (wr) begin
        store[widx] <= rx.rx_byte;
      end
      sum <= sum_next;
      if (accept && rx.frame_end) begin
        pos <= '0;
      end else if (wr) begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

@@ rtl/rcsb_queue.sv @@
// ----------------------------------------------------------------------------
// rcsb_queue: short queue of classified frames
// Decouples the byte front end from the decode back end.
// ----------------------------------------------------------------------------
module rcsb_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push_valid,
  output logic                        push_ready,
  input  rcsb_pkg::rcsb_frame_t       push_entry,
  output logic                        head_valid,
  input  logic                        pop,
  output rcsb_pkg::rcsb_frame_t       head_entry,
  output rcsb_pkg::rcsb_queue_status_t status
);

  rcsb_pkg::rcsb_frame_t entries [rcsb_pkg::QUEUE_DEPTH];
  logic [rcsb_pkg::QPTR_W-1:0] wptr;
  logic [rcsb_pkg::QPTR_W-1:0] rptr;
  logic [rcsb_pkg::QCNT_W-1:0] count;
  logic                        do_push;
  logic                        do_pop;

  function automatic logic [rcsb_pkg::QPTR_W-1:0] ptr_inc(input logic [rcsb_pkg::QPTR_W-1:0] p);
    if (p == rcsb_pkg::QPTR_W'(rcsb_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign status.count = count;
  assign status.full  = (count == rcsb_pkg::QCNT_W'(rcsb_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign push_ready   = !status.full;
  assign head_valid   = !status.empty;
  assign head_entry   = entries[rptr];
  assign do_push      = push_valid && push_ready;
  assign do_pop       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= ptr_inc(wptr);
      end
      if (do_pop) begin
        rptr <= ptr_inc(rptr);
      end
      count <= count + rcsb_pkg::QCNT_W'(do_push) - rcsb_pkg::QCNT_W'(do_pop);
    end
  end

endmodule

@@ rtl/rcsb_back.sv @@
// ----------------------------------------------------------------------------
// rcsb_back: channel update and output mapping
// Holds the last good channels, applies deadband, switch quantization and
// knob pass-through in two register stages, the second being the output.
// ----------------------------------------------------------------------------
module rcsb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  rcsb_pkg::rcsb_frame_t head_entry,
  output logic                  pop,
  rcsb_result_if.source         res
);

  logic [rcsb_pkg::NUM_CH-1:0][rcsb_pkg::CH_W-1:0] channel_values;
  logic [rcsb_pkg::NUM_CH-1:0][rcsb_pkg::CH_W-1:0] ch_sel;
  logic adv;

  logic                                                s1_valid;
  logic                                                s1_ok;
  logic [rcsb_pkg::NUM_STICKS-1:0][rcsb_pkg::CH_W-1:0] s1_stick;
  logic [rcsb_pkg::NUM_KNOBS-1:0][rcsb_pkg::CH_W-1:0]  s1_knob;
  logic [rcsb_pkg::NUM_SWITCHES-1:0][rcsb_pkg::MAG_W-1:0] s1_mag;
  logic [rcsb_pkg::NUM_SWITCHES-1:0]                   s1_neg;

  logic [rcsb_pkg::NUM_STICKS-1:0][rcsb_pkg::CH_W-1:0]  stick_map;
  logic [rcsb_pkg::NUM_SWITCHES-1:0][rcsb_pkg::MAG_W-1:0] mag_map;
  logic [rcsb_pkg::NUM_SWITCHES-1:0]                    neg_map;
  logic [rcsb_pkg::NUM_SWITCHES-1:0][7:0]               switch_map;

  logic                                                out_valid;
  logic                                                out_ok;
  logic [rcsb_pkg::NUM_STICKS-1:0][rcsb_pkg::CH_W-1:0] out_stick;
  logic [rcsb_pkg::NUM_SWITCHES-1:0][7:0]              out_switch;
  logic [rcsb_pkg::NUM_KNOBS-1:0][rcsb_pkg::CH_W-1:0]  out_knob;

  assign adv = !out_valid || res.ready;
  assign pop = adv && head_valid;

  assign ch_sel = head_entry.ok ? head_entry.ch : channel_values;

  always_comb begin
    logic [rcsb_pkg::CH_W-1:0] v;
    for (int k = 0; k < rcsb_pkg::NUM_STICKS; k++) begin
      v = ch_sel[rcsb_pkg::STICK_BASE + k];
      if (($signed(v) > -rcsb_pkg::DEADBAND) && ($signed(v) < rcsb_pkg::DEADBAND)) begin
        stick_map[k] = '0;
      end else begin
        stick_map[k] = v;
      end
    end
    for (int k = 0; k < rcsb_pkg::NUM_SWITCHES; k++) begin
      v = ch_sel[rcsb_pkg::SWITCH_BASE + k];
      neg_map[k] = v[rcsb_pkg::CH_W-1];
      mag_map[k] = v[rcsb_pkg::CH_W-1] ? (rcsb_pkg::MAG_W'(0) - {v[rcsb_pkg::CH_W-1], v})
                                       : {1'b0, v};
    end
  end

  // Truncating division: magnitude times reciprocal, then the sign back on.
  always_comb begin
    logic [rcsb_pkg::PROD_W-1:0]     prod;
    logic [rcsb_pkg::SWITCH_Q_W-1:0] q;
    for (int k = 0; k < rcsb_pkg::NUM_SWITCHES; k++) begin
      prod = rcsb_pkg::PROD_W'(s1_mag[k]) * rcsb_pkg::PROD_W'(rcsb_pkg::SWITCH_RECIP);
      q    = prod[rcsb_pkg::SWITCH_RECIP_SHIFT +: rcsb_pkg::SWITCH_Q_W];
      switch_map[k] = s1_neg[k] ? (8'd0 - {1'b0, q}) : {1'b0, q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_values <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else if (adv) begin
      if (head_valid && head_entry.ok) begin
        channel_values <= head_entry.ch;
      end
      s1_valid  <= head_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ok    <= head_entry.ok;
      s1_stick <= stick_map;
      s1_mag   <= mag_map;
      s1_neg   <= neg_map;
      for (int k = 0; k < rcsb_pkg::NUM_KNOBS; k++) begin
        s1_knob[k] <= ch_sel[rcsb_pkg::KNOB_BASE + k];
      end
      out_ok     <= s1_ok;
      out_stick  <= s1_stick;
      out_knob   <= s1_knob;
      out_switch <= switch_map;
    end
  end

  assign res.valid         = out_valid;
  assign res.stick_right_x = out_stick[0];
  assign res.stick_right_y = out_stick[1];
  assign res.stick_left_y  = out_stick[2];
  assign res.stick_left_x  = out_stick[3];
  assign res.switch_a      = out_switch[0];
  assign res.switch_b      = out_switch[1];
  assign res.switch_c      = out_switch[2];
  assign res.switch_d      = out_switch[3];
  assign res.knob_a        = out_knob[0];
  assign res.knob_b        = out_knob[1];
  assign res.frame_ok      = out_ok;

endmodule

@@ rtl/rc_sbus_ibus_frame_decoder_core.sv @@
// ----------------------------------------------------------------------------
// rc_sbus_ibus_frame_decoder_core: SBUS / IBUS radio-control frame decoder
// Collects received bytes into a frame store and decodes each closed buffer
// into stick, switch and knob values.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received byte per beat; frame_end marks the last byte of
//   a buffer. res carries one result beat for every frame-end beat, in order.
//   The APB port holds protocol_mode at address 0 (0 = SBUS, 1 = IBUS);
//   the user must write it only while no frame is in flight (not enforced).
//   Throughput is one byte per cycle, frame-end bytes included, while the
//   frame queue is not full. A frame-end beat's result passes through the
//   frame queue, the mapping stage and then the output register, each held
//   while res is stalled. The rate is set by the byte front end, which
//   updates the store and checksum sum once per cycle.
//   When res is stalled the result holds in the output register, the mapping
//   stage holds, and the two-entry frame queue absorbs further frame-end
//   bytes; rx.ready drops only once that queue is full.
//   Reset clears the frame store, the stored channels, the byte position,
//   protocol_mode and all valid state; no result is pending after reset.
// ----------------------------------------------------------------------------
module rc_sbus_ibus_frame_decoder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rcsb_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  rcsb_byte_if.sink                     rx,
  rcsb_result_if.source                 res
);

  logic                         protocol_mode;
  logic                         cfg_write;
  logic                         push_valid;
  logic                         push_ready;
  rcsb_pkg::rcsb_frame_t        push_entry;
  logic                         head_valid;
  logic                         pop;
  rcsb_pkg::rcsb_frame_t        head_entry;
  rcsb_pkg::rcsb_queue_status_t q_status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[rcsb_pkg::PADDR_W-1:2] == rcsb_pkg::REG_PROTOCOL_MODE);
  assign prdata    = (paddr[rcsb_pkg::PADDR_W-1:2] == rcsb_pkg::REG_PROTOCOL_MODE)
                     ? {31'd0, protocol_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode <= rcsb_pkg::MODE_SBUS;
    end else if (cfg_write) begin
      protocol_mode <= pwdata[0];
    end
  end

  rcsb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .protocol_mode (protocol_mode),
    .rx            (rx),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  rcsb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .head_valid (head_valid),
    .pop        (pop),
    .head_entry (head_entry),
    .status     (q_status)
  );

  rcsb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .res        (res)
  );

  // The queue never holds more frames than it has entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= rcsb_pkg::QCNT_W'(rcsb_pkg::QUEUE_DEPTH))
    else $error("frame queue count beyond depth");

  // Nothing is pending right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !res.valid && q_status.empty)
    else $error("result or queued frame after reset");

  // Switch positions A and D stay within the range a 16-bit channel can give.
  a_switch_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> ($signed(res.switch_a) <= 65) && ($signed(res.switch_a) >= -65) &&
                  ($signed(res.switch_d) <= 65) && ($signed(res.switch_d) >= -65))
    else $error("switch position out of range");

  // A right stick X value inside the deadband must have been forced to zero.
  a_deadband: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.stick_right_x == 16'sd0) || ($signed(res.stick_right_x) >= 10) ||
                  ($signed(res.stick_right_x) <= -10))
    else $error("stick value inside deadband");

endmodule

@@ tb/sv/tb_rc_sbus_ibus_frame_decoder_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rc_sbus_ibus_frame_decoder_core: self-checking bench for the RC decoder
// Streams SBUS and IBUS byte buffers (well-formed, corrupted, short, overlong
// and noise) into the decoder under random sender and receiver gaps. Channel
// state is tracked alongside the design, and every result beat is compared
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_rc_sbus_ibus_frame_decoder_core;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          SBUS_WIRE_CH   = 16;
  localparam int          IBUS_WIRE_CH   = 14;
  localparam logic [rcsb_pkg::PADDR_W-1:0] MODE_ADDR = {rcsb_pkg::REG_PROTOCOL_MODE, 2'b00};

  typedef struct packed {
    logic [3:0][15:0] stick;
    logic [3:0][7:0]  sw;
    logic [1:0][15:0] knob;
    logic             ok;
  } rc_outputs_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [rcsb_pkg::PADDR_W-1:0]  paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  rcsb_byte_if   rx_bus ();
  rcsb_result_if res_bus ();

  rc_sbus_ibus_frame_decoder_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx      (rx_bus),
    .res     (res_bus)
  );

  // Mirror of the decoder state.
  logic [7:0]  store_mirror [rcsb_pkg::BUFFER_BYTES];
  int unsigned fill_pos;
  logic [15:0] ch_mirror [rcsb_pkg::NUM_CH];
  logic        mode_mirror;
  rc_outputs_t outputs_due [$];

  logic [7:0]  frame_bytes [$];
  logic [10:0] sbus_raw [SBUS_WIRE_CH];
  logic [15:0] ibus_raw [IBUS_WIRE_CH];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned bytes_sent;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  rc_outputs_t want_out;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] byte_at(int idx);
    if (idx >= rcsb_pkg::BUFFER_BYTES) return 8'h00;
    return store_mirror[idx];
  endfunction

  function automatic logic unpack_sbus();
    int          bitpos;
    int          b;
    logic [23:0] w;
    logic [10:0] raw;
    if (byte_at(0) != rcsb_pkg::SBUS_SYNC) return 1'b0;
    for (int k = 0; k < rcsb_pkg::NUM_CH; k++) begin
      bitpos = rcsb_pkg::SBUS_CH_W * k;
      b      = 1 + bitpos / 8;
      w      = {byte_at(b + 2), byte_at(b + 1), byte_at(b)};
      raw    = 11'(w >> (bitpos % 8));
      ch_mirror[k] = {5'b0, raw} - rcsb_pkg::SBUS_OFFSET;
    end
    return 1'b1;
  endfunction

  function automatic logic unpack_ibus();
    logic [15:0] sum;
    if (byte_at(0) != rcsb_pkg::IBUS_SYNC) return 1'b0;
    sum = rcsb_pkg::CKSUM_INIT;
    for (int k = 0; k < rcsb_pkg::CKSUM_BYTES; k++) sum = sum - 16'(byte_at(k));
    if (sum != {byte_at(rcsb_pkg::CKSUM_HI_IDX), byte_at(rcsb_pkg::CKSUM_LO_IDX)}) return 1'b0;
    for (int k = 0; k < rcsb_pkg::NUM_CH; k++)
      ch_mirror[k] = {byte_at(3 + 2 * k), byte_at(2 + 2 * k)} - rcsb_pkg::IBUS_CENTER;
    return 1'b1;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic fe);
    rc_outputs_t o;
    logic        ok;
    int          s;
    int          q;
    if (fill_pos < rcsb_pkg::BUFFER_BYTES) begin
      store_mirror[fill_pos] = b;
      fill_pos++;
    end
    if (!fe) return;
    fill_pos = 0;
    ok = (mode_mirror == rcsb_pkg::MODE_SBUS) ? unpack_sbus() : unpack_ibus();
    for (int k = 0; k < rcsb_pkg::NUM_STICKS; k++) begin
      s = $signed(ch_mirror[rcsb_pkg::STICK_BASE + k]);
      o.stick[k] = (s > -rcsb_pkg::DEADBAND && s < rcsb_pkg::DEADBAND)
                   ? 16'h0000 : ch_mirror[rcsb_pkg::STICK_BASE + k];
    end
    for (int k = 0; k < rcsb_pkg::NUM_SWITCHES; k++) begin
      s = $signed(ch_mirror[rcsb_pkg::SWITCH_BASE + k]);
      q = s / rcsb_pkg::SWITCH_DIV;
      o.sw[k] = q[7:0];
    end
    o.knob[0] = ch_mirror[rcsb_pkg::KNOB_BASE];
    o.knob[1] = ch_mirror[rcsb_pkg::KNOB_BASE + 1];
    o.ok      = ok;
    outputs_due.push_back(o);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic fe);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_bus.valid = 1'b0;
      @(negedge clk);
    end
    rx_bus.valid     = 1'b1;
    rx_bus.rx_byte   = b;
    rx_bus.frame_end = fe;
    do @(posedge clk); while (!rx_bus.ready);
    absorb_byte(b, fe);
    bytes_sent++;
    @(negedge clk);
    rx_bus.valid = 1'b0;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic apb_xfer(input logic wr, input logic [rcsb_pkg::PADDR_W-1:0] a,
                          input logic [31:0] wd, output logic [31:0] rd);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = a;
    pwdata  = wd;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic drain_results();
    while (outputs_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    logic [31:0] rd;
    drain_results();
    apb_xfer(1'b1, MODE_ADDR, 32'(m), rd);
    mode_mirror = m;
    apb_xfer(1'b0, MODE_ADDR, 32'h0, rd);
    if (rd !== 32'(m)) begin
      mismatch_count++;
      $display("%0t: protocol_mode readback expected %0h actual %0h", $time, m, rd);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Frame construction
  // ---------------------------------------------------------------------------
  function automatic logic [10:0] pick_sbus_raw();
    int v;
    case ($urandom_range(5))
      0: v = 1024 - 12 + $urandom_range(24);
      1: v = $urandom_range(1) ? 2047 : 0;
      2: v = 1024 + ($urandom_range(1) ? 500 : -500) * $urandom_range(2, 1)
             + $urandom_range(2) - 1;
      default: v = $urandom_range(2047);
    endcase
    return 11'(v);
  endfunction

  function automatic logic [15:0] pick_ibus_raw();
    int v;
    case ($urandom_range(5))
      0: v = 1500 - 12 + $urandom_range(24);
      1: begin
        case ($urandom_range(3))
          0: v = 0;
          1: v = 16'hFFFF;
          2: v = 1500 + 32767;
          default: v = 1500 + 32768;
        endcase
      end
      2: v = 1500 + ($urandom_range(1) ? 500 : -500) * $urandom_range(65, 1)
             + $urandom_range(2) - 1;
      3: v = $urandom_range(2000, 1000);
      default: v = $urandom_range(16'hFFFF);
    endcase
    return 16'(v);
  endfunction

  task automatic build_sbus_frame();
    logic [SBUS_WIRE_CH*rcsb_pkg::SBUS_CH_W-1:0] bits;
    for (int k = 0; k < SBUS_WIRE_CH; k++)
      bits[rcsb_pkg::SBUS_CH_W*k +: rcsb_pkg::SBUS_CH_W] = sbus_raw[k];
    frame_bytes = {};
    frame_bytes.push_back(rcsb_pkg::SBUS_SYNC);
    for (int i = 0; i < SBUS_WIRE_CH * rcsb_pkg::SBUS_CH_W / 8; i++)
      frame_bytes.push_back(bits[8*i +: 8]);
    // Flag byte and end byte carry nothing the decoder uses.
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
  endtask

  task automatic build_ibus_frame();
    logic [15:0] sum;
    frame_bytes = {};
    frame_bytes.push_back(rcsb_pkg::IBUS_SYNC);
    frame_bytes.push_back(8'h40);
    for (int k = 0; k < IBUS_WIRE_CH; k++) begin
      frame_bytes.push_back(ibus_raw[k][7:0]);
      frame_bytes.push_back(ibus_raw[k][15:8]);
    end
    sum = rcsb_pkg::CKSUM_INIT;
    for (int i = 0; i < rcsb_pkg::CKSUM_BYTES; i++) sum = sum - 16'(frame_bytes[i]);
    frame_bytes.push_back(sum[7:0]);
    frame_bytes.push_back(sum[15:8]);
  endtask

  task automatic build_valid(input logic m);
    if (m == rcsb_pkg::MODE_SBUS) begin
      foreach (sbus_raw[k]) sbus_raw[k] = pick_sbus_raw();
      build_sbus_frame();
    end else begin
      foreach (ibus_raw[k]) ibus_raw[k] = pick_ibus_raw();
      build_ibus_frame();
    end
  endtask

  function automatic logic [7:0] mode_header();
    return (mode_mirror == rcsb_pkg::MODE_SBUS) ? rcsb_pkg::SBUS_SYNC : rcsb_pkg::IBUS_SYNC;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_sbus_corners();
    set_mode(rcsb_pkg::MODE_SBUS);
    // The store is still all zero, so every channel decodes to its minimum.
    send_byte(rcsb_pkg::SBUS_SYNC, 1'b1);
    foreach (sbus_raw[k]) sbus_raw[k] = pick_sbus_raw();
    sbus_raw[0] = 11'd1033;
    sbus_raw[1] = 11'd1015;
    sbus_raw[2] = 11'd1034;
    sbus_raw[3] = 11'd1014;
    sbus_raw[4] = 11'd1523;
    sbus_raw[5] = 11'd524;
    sbus_raw[6] = 11'd2023;
    sbus_raw[7] = 11'd24;
    sbus_raw[8] = 11'd0;
    sbus_raw[9] = 11'd2047;
    build_sbus_frame();
    send_frame();
    // Bad header keeps the channels; a header-only buffer reuses the old bytes.
    send_byte(8'h00, 1'b1);
    send_byte(rcsb_pkg::SBUS_SYNC, 1'b1);
  endtask

  task automatic test_ibus_corners();
    set_mode(rcsb_pkg::MODE_IBUS);
    foreach (ibus_raw[k]) ibus_raw[k] = pick_ibus_raw();
    ibus_raw[0] = 16'd1509;
    ibus_raw[1] = 16'd1491;
    ibus_raw[2] = 16'd0;
    ibus_raw[3] = 16'hFFFF;
    ibus_raw[4] = 16'(1500 + 32767);
    ibus_raw[5] = 16'(1500 + 32768);
    ibus_raw[6] = 16'd1999;
    ibus_raw[7] = 16'd1000;
    ibus_raw[8] = 16'(1500 + 32767);
    ibus_raw[9] = 16'(1500 + 32768);
    build_ibus_frame();
    send_frame();
    // Changing byte 1 alone breaks the checksum of the stored frame.
    send_byte(rcsb_pkg::IBUS_SYNC, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned r;
    int unsigned n;
    int unsigned idx;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 62) begin
        build_valid(mode_mirror);
      end else if (r < 70) begin
        build_valid(~mode_mirror);
      end else if (r < 78) begin
        build_valid(mode_mirror);
        idx = $urandom_range(frame_bytes.size() - 1);
        frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(7));
      end else if (r < 86) begin
        // Overlong buffer: the tail past the store is dropped.
        build_valid(mode_mirror);
        repeat ($urandom_range(12, 1)) frame_bytes.push_back(8'($urandom));
      end else if (r < 94) begin
        frame_bytes = {mode_header()};
        repeat ($urandom_range(10)) frame_bytes.push_back(8'($urandom));
      end else begin
        n = $urandom_range(40, 1);
        frame_bytes = {};
        repeat (n) frame_bytes.push_back(8'($urandom));
      end
      send_frame();
    end
  endtask

  task automatic test_backpressure();
    hold_request = 400;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 0) build_valid(mode_mirror);
      else frame_bytes = {mode_header()};
      send_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      res_bus.ready = 1'b0;
      hold_left--;
    end else begin
      res_bus.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic cmp_field(input string label, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (outputs_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with nothing expected", $time);
      end else begin
        want_out = outputs_due.pop_front();
        cmp_field("stick_right_x", $signed(want_out.stick[0]), res_bus.stick_right_x);
        cmp_field("stick_right_y", $signed(want_out.stick[1]), res_bus.stick_right_y);
        cmp_field("stick_left_y",  $signed(want_out.stick[2]), res_bus.stick_left_y);
        cmp_field("stick_left_x",  $signed(want_out.stick[3]), res_bus.stick_left_x);
        cmp_field("switch_a",      $signed(want_out.sw[0]),    res_bus.switch_a);
        cmp_field("switch_b",      $signed(want_out.sw[1]),    res_bus.switch_b);
        cmp_field("switch_c",      $signed(want_out.sw[2]),    res_bus.switch_c);
        cmp_field("switch_d",      $signed(want_out.sw[3]),    res_bus.switch_d);
        cmp_field("knob_a",        $signed(want_out.knob[0]),  res_bus.knob_a);
        cmp_field("knob_b",        $signed(want_out.knob[1]),  res_bus.knob_b);
        cmp_field("frame_ok",      int'(want_out.ok),          int'(res_bus.frame_ok));
      end
    end
  end

  // Ends the run when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    rx_bus.valid     = 1'b0;
    rx_bus.rx_byte   = 8'h00;
    rx_bus.frame_end = 1'b0;
    res_bus.ready    = 1'b0;
    src_idle_pct     = 16;
    sink_idle_pct    = 74;
    hold_request     = 0;
    hold_left        = 0;
    bytes_sent       = 0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    foreach (store_mirror[i]) store_mirror[i] = 8'h00;
    foreach (ch_mirror[i]) ch_mirror[i] = 16'h0000;
    fill_pos    = 0;
    mode_mirror = rcsb_pkg::MODE_SBUS;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_sbus_corners();
    test_random_traffic(130);
    test_ibus_corners();
    test_random_traffic(130);

    src_idle_pct  = 74;
    sink_idle_pct = 16;
    set_mode(rcsb_pkg::MODE_SBUS);
    test_random_traffic(120);
    set_mode(rcsb_pkg::MODE_IBUS);
    test_random_traffic(120);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_backpressure();
    test_random_traffic(85);
    set_mode(rcsb_pkg::MODE_SBUS);
    test_backpressure();
    test_random_traffic(85);

    drain_results();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ rc_sbus_ibus_frame_decoder_core.f @@
rtl/rcsb_pkg.sv
rtl/rcsb_if.sv
rtl/rcsb_front.sv
rtl/rcsb_queue.sv
rtl/rcsb_back.sv
rtl/rc_sbus_ibus_frame_decoder_core.sv
tb/sv/tb_rc_sbus_ibus_frame_decoder_core.sv
